FILE: rtl/core/cea_pkg.sv
package cea_pkg;

    localparam int unsigned PosW    = 32;
    localparam int unsigned ThickW  = 21;
    localparam int unsigned SideW   = 22;
    localparam int unsigned ScaleW  = 24;
    localparam int unsigned TotalW  = 48;
    localparam int unsigned DistW   = 34;
    localparam int unsigned AreaW   = 39;
    localparam int unsigned VolW    = 45;
    localparam int unsigned AccW    = 70;
    localparam int unsigned IndexW  = 8;
    localparam int unsigned CfgW    = 24;

    localparam logic [SideW-1:0]  SideStepReset      = SideW'(26214);
    localparam logic [ScaleW-1:0] FilamentScaleReset = ScaleW'(6975189);

    // register indexes of the configuration port
    localparam logic [IndexW-1:0] RegSideStep      = IndexW'(0);
    localparam logic [IndexW-1:0] RegFilamentScale = IndexW'(1);

    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic [ThickW-1:0]      thick;
        logic                   extrude;
    } in_item_t;

    typedef struct packed {
        logic [TotalW-1:0] extrusion_total;
        logic [TotalW-1:0] path_length_total;
    } out_item_t;

    // operand selection of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_SQ_Z,
        MUL_AREA,
        MUL_VOL,
        MUL_FEED
    } mul_op_t;

    // intermediate results captured from the accumulator
    typedef enum logic [1:0] {
        LAT_NONE,
        LAT_D2,
        LAT_AREA,
        LAT_VOL
    } latch_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    high_half;
        logic    acc_clear;
        latch_t  latch;
        logic    sqrt_step;
        logic    commit;
    } dp_cmd_t;

    typedef struct packed {
        logic have_last;
    } dp_status_t;

endpackage

FILE: rtl/core/cea_dp.sv
module cea_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cea_pkg::dp_cmd_t            cmd,
    output cea_pkg::dp_status_t         status,
    input  cea_pkg::in_item_t           in_data,
    input  logic                        cfg_we,
    input  logic [cea_pkg::IndexW-1:0]  cfg_index,
    input  logic [cea_pkg::CfgW-1:0]    cfg_data,
    output cea_pkg::out_item_t          totals
);
    import cea_pkg::*;

    logic [SideW-1:0]       side_step_reg;
    logic [ScaleW-1:0]      filament_scale_reg;
    logic [PosW-1:0]        last_x_reg, last_y_reg, last_z_reg;
    logic [ThickW-1:0]      last_thick_reg;
    logic                   have_last_reg;
    logic [PosW-1:0]        ax_reg, ay_reg, az_reg;
    logic [ThickW:0]        tsum_reg;
    logic [AccW-1:0]        acc_reg, acc_next;
    logic [67:0]            rad_reg;
    logic [36:0]            rem_reg;
    logic [DistW-1:0]       root_reg;
    logic [AreaW-1:0]       area_reg;
    logic [VolW-1:0]        vol_reg;
    logic [TotalW-1:0]      ext_total_reg, len_total_reg;
    logic [PosW:0]          dx, dy, dz;
    logic [PosW-1:0]        sq_op;
    logic [33:0]            mul_a;
    logic [23:0]            mul_b;
    logic [57:0]            prod;
    logic [AccW-1:0]        addend;
    logic [36:0]            rem_shift, trial;
    logic                   rem_ge;
    logic [VolW-1:0]        feed;
    logic [TotalW:0]        ext_sum, len_sum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_step_reg      <= SideStepReset;
            filament_scale_reg <= FilamentScaleReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegSideStep:      side_step_reg      <= cfg_data[SideW-1:0];
                RegFilamentScale: filament_scale_reg <= cfg_data[ScaleW-1:0];
                default:          ;
            endcase
        end
    end

    // signed differences to the previous point
    assign dx = {in_data.pos_x[PosW-1], in_data.pos_x} - {last_x_reg[PosW-1], last_x_reg};
    assign dy = {in_data.pos_y[PosW-1], in_data.pos_y} - {last_y_reg[PosW-1], last_y_reg};
    assign dz = {in_data.pos_z[PosW-1], in_data.pos_z} - {last_z_reg[PosW-1], last_z_reg};

    // previous point and magnitudes of the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_z_reg     <= '0;
            last_thick_reg <= '0;
            have_last_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            last_x_reg     <= in_data.pos_x;
            last_y_reg     <= in_data.pos_y;
            last_z_reg     <= in_data.pos_z;
            last_thick_reg <= in_data.thick;
            have_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg   <= dx[PosW] ? PosW'(~dx + 1'b1) : dx[PosW-1:0];
            ay_reg   <= dy[PosW] ? PosW'(~dy + 1'b1) : dy[PosW-1:0];
            az_reg   <= dz[PosW] ? PosW'(~dz + 1'b1) : dz[PosW-1:0];
            tsum_reg <= {1'b0, in_data.thick} + {1'b0, last_thick_reg};
        end
    end

    assign status.have_last = have_last_reg;

    // operand selection, wide operands split into 24-bit chunks
    always_comb
    begin
        case (cmd.mul_op)
            MUL_SQ_X: sq_op = ax_reg;
            MUL_SQ_Y: sq_op = ay_reg;
            default:  sq_op = az_reg;
        endcase
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_SQ_X, MUL_SQ_Y, MUL_SQ_Z:
            begin
                mul_a = {2'b0, sq_op};
                mul_b = cmd.high_half ? {16'b0, sq_op[31:24]} : sq_op[23:0];
            end
            MUL_AREA:
            begin
                mul_a = root_reg;
                mul_b = {2'b0, tsum_reg};
            end
            MUL_VOL:
            begin
                mul_a = {12'b0, side_step_reg};
                mul_b = cmd.high_half ? {9'b0, area_reg[38:24]} : area_reg[23:0];
            end
            MUL_FEED:
            begin
                mul_a = cmd.high_half ? {13'b0, vol_reg[44:24]} : {10'b0, vol_reg[23:0]};
                mul_b = filament_scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiply-accumulate
    assign prod   = 58'(mul_a) * 58'(mul_b);
    assign addend = cmd.high_half ? {prod[45:0], 24'b0} : {12'b0, prod};

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_op != MUL_NONE)
        begin
            acc_next = cmd.acc_clear ? addend : acc_reg + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (cmd.latch)
            LAT_AREA: area_reg <= acc_reg[55:17];
            LAT_VOL:  vol_reg  <= acc_reg[60:16];
            default:  ;
        endcase
    end

    // bit-serial square root, one result bit a cycle
    assign rem_shift = {rem_reg[34:0], rad_reg[67:66]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign rem_ge    = rem_shift >= trial;

    always_ff @(posedge clk)
    begin
        if (cmd.latch == LAT_D2)
        begin
            rad_reg  <= {2'b0, acc_reg[65:0]};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[65:0], 2'b0};
            rem_reg  <= rem_ge ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[DistW-2:0], rem_ge};
        end
    end

    // saturating totals
    assign feed    = acc_reg[68:24];
    assign ext_sum = {1'b0, ext_total_reg} + (TotalW+1)'(feed);
    assign len_sum = {1'b0, len_total_reg} + (TotalW+1)'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_total_reg <= '0;
            len_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            ext_total_reg <= ext_sum[TotalW] ? {TotalW{1'b1}} : ext_sum[TotalW-1:0];
            len_total_reg <= len_sum[TotalW] ? {TotalW{1'b1}} : len_sum[TotalW-1:0];
        end
    end

    assign totals.extrusion_total   = ext_total_reg;
    assign totals.path_length_total = len_total_reg;

endmodule

FILE: rtl/core/cea_ctrl.sv
module cea_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_extrude,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cea_pkg::dp_cmd_t     cmd,
    input  cea_pkg::dp_status_t  status
);
    import cea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQRT_LD,
        S_SQRT,
        S_AREA,
        S_AREA_LT,
        S_VOL,
        S_VOL_LT,
        S_FEED,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       ext_reg, ext_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, slot_free, fire;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign fire      = (state_reg == S_FIN) && slot_free;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.mul_op    = MUL_NONE;
        cmd.latch     = LAT_NONE;
        cmd.load      = accept;
        case (state_reg)
            S_SQ:
            begin
                case (cnt_reg[2:1])
                    2'd0:    cmd.mul_op = MUL_SQ_X;
                    2'd1:    cmd.mul_op = MUL_SQ_Y;
                    default: cmd.mul_op = MUL_SQ_Z;
                endcase
                cmd.high_half = cnt_reg[0];
                cmd.acc_clear = cnt_reg == '0;
            end
            S_SQRT_LD: cmd.latch = LAT_D2;
            S_SQRT:    cmd.sqrt_step = 1'b1;
            S_AREA:
            begin
                cmd.mul_op    = MUL_AREA;
                cmd.acc_clear = 1'b1;
            end
            S_AREA_LT: cmd.latch = LAT_AREA;
            S_VOL:
            begin
                cmd.mul_op    = MUL_VOL;
                cmd.high_half = cnt_reg[0];
                cmd.acc_clear = !cnt_reg[0];
            end
            S_VOL_LT:  cmd.latch = LAT_VOL;
            S_FEED:
            begin
                cmd.mul_op    = MUL_FEED;
                cmd.high_half = cnt_reg[0];
                cmd.acc_clear = !cnt_reg[0];
            end
            S_FIN:     cmd.commit = fire && ext_reg;
            default:   ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + 6'd1;
        ext_next       = ext_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    ext_next   = in_extrude && status.have_last;
                    state_next = ext_next ? S_SQ : S_FIN;
                end
            end
            S_SQ:
            begin
                if (cnt_reg == 6'd5)
                begin
                    state_next = S_SQRT_LD;
                end
            end
            S_SQRT_LD:
            begin
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == 6'(DistW - 1))
                begin
                    state_next = S_AREA;
                end
            end
            S_AREA:    state_next = S_AREA_LT;
            S_AREA_LT:
            begin
                cnt_next   = '0;
                state_next = S_VOL;
            end
            S_VOL:
            begin
                if (cnt_reg[0])
                begin
                    state_next = S_VOL_LT;
                end
            end
            S_VOL_LT:
            begin
                cnt_next   = '0;
                state_next = S_FEED;
            end
            S_FEED:
            begin
                if (cnt_reg[0])
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ext_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is only issued into a free output slot
    a_fire_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(out_valid_reg && out_stall))
        else $error("result issued over a pending one");

    // root counter stays within the result width
    a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (cnt_reg < 6'(DistW)))
        else $error("square root ran past its last bit");

    // totals only move on an extruding item
    a_commit_ext: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (ext_reg && state_reg == S_FIN))
        else $error("totals updated for a travel move");

    // a taken result with nothing new leaves the slot empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !fire) |=> !out_valid_reg)
        else $error("output slot not released");

endmodule

FILE: rtl/core/cumulative_extrusion_accumulator.sv
// one request at a time: in_stall stays high from a taken request until its result is issued,
// and an output stall holds the result back; a travel request goes straight to its result
// the extruding path runs through a bit-serial square root and a shared
// 34x24 multiply-accumulate used for 11 passes
// reset (asynchronous, active low) clears the totals, the previous point and
// loads the default side step and filament scale
module cumulative_extrusion_accumulator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cea_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cea_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cea_pkg::IndexW-1:0]  cfg_index,
    input  logic [cea_pkg::CfgW-1:0]    cfg_data
);
    import cea_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cea_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_extrude (in_data.extrude),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status)
    );

    cea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .totals    (out_data)
    );

endmodule
